/* src/outstanding_request_tracker_macros.svh */
// Assertion helpers for the request tracker.
// All checks sample on clk and are off while arst_n is low.
`ifndef OUTSTANDING_REQUEST_TRACKER_MACROS_SVH
`define OUTSTANDING_REQUEST_TRACKER_MACROS_SVH

// cond must hold at every edge
`define ORT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ORT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define ORT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ort_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ort_pkg;

	localparam logic [2:0] CMD_ADD      = 3'd0;
	localparam logic [2:0] CMD_REMOVE   = 3'd1;
	localparam logic [2:0] CMD_COMPLETE = 3'd2;
	localparam logic [2:0] CMD_CHECK    = 3'd3;
	localparam logic [2:0] CMD_CANCEL   = 3'd4;

	localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [1:0] CFG_CALLABLE = 2'd1;

	localparam logic [31:0] TIMEOUT_RESET  = 32'd10;
	localparam logic [15:0] TIMEOUT_STATUS = 16'd504;

	// per-slot payload kept beside the handler word
	typedef struct packed {
		logic [31:0] ctx;
		logic [3:0]  kind;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic wr_data_en;
		logic rd_en;
	} mem_ctl_t;

	typedef struct packed {
		logic        fired;
		logic        ok;
		logic [15:0] index;
		logic [31:0] handler;
		logic [31:0] ctx;
		logic [3:0]  kind;
		logic [15:0] status;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

/* src/ort_slot_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module ort_slot_mem import ort_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int SW    = 4
) (
	input  logic          clk,
	input  mem_ctl_t      ctl,
	input  logic [SW-1:0] wr_addr,
	input  logic [31:0]   wr_hdl,
	input  entry_t        wr_entry,
	input  logic [SW-1:0] rd_addr,
	output logic [31:0]   rd_hdl,
	output entry_t        rd_entry
);

	logic [31:0] hdl_mem [DEPTH];
	entry_t      ent_mem [DEPTH];

	// handler word is written alone on invalidate, with the payload on add
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			hdl_mem[wr_addr] <= wr_hdl;
		end
		if (ctl.wr_en && ctl.wr_data_en) begin
			ent_mem[wr_addr] <= wr_entry;
		end
		if (ctl.rd_en) begin
			rd_hdl   <= hdl_mem[rd_addr];
			rd_entry <= ent_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* src/ort_sub_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module ort_sub_unit (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] diff,
	output logic        borrow
);

	// borrow set means a < b
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

`default_nettype wire

/* src/outstanding_request_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Outstanding request tracker: a ring of DEPTH pending requests keyed by sequence index.
// Command channel: an item is taken when start is high and busy is low; cmd picks
// add, remove, complete, check timeouts or cancel all. Each result shows for one
// cycle with result_valid high; last marks the done result that ends a command.
// Firings (fired = 1) come before the done result, one per qualifying entry.
// Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; cfg_ready is always
// high. Index 0 is timeout_ticks, index 1 callable_kind; other indexes are ignored.
// Each command ends with its done result, and the next item can be taken at the edge that
// takes that result. After a complete that hits the head, busy stays high past the done
// result while invalid entries are swept from the head, until a live entry stops the sweep
// or the ring is empty. Check and cancel on an empty ring give only the done result.
// Otherwise check walks from the head, dropping invalid and expired entries, until a live
// unexpired entry stops the walk or the ring is empty; cancel reads every entry. The
// single-port slot memory (one read a cycle) and the shared 32-bit subtractor (offset math
// and timeout compare) set the pace of these walks.
// The longest command with DEPTH = 16 is a check over a full expired ring.
// Reset clears the ring (fill 0, head 0, newest index 0) and the config registers
// to their defaults; slot contents are not cleared. The receiver cannot stall:
// every result is taken in the cycle it is shown.

`include "outstanding_request_tracker_macros.svh"

module outstanding_request_tracker import ort_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [31:0] handler,
	input  logic [3:0]  entry_kind_in,
	input  logic [31:0] context_in,
	input  logic [15:0] seq_index,
	input  logic [31:0] now,
	input  logic [15:0] cancel_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic        fired,
	output logic        ok,
	output logic [15:0] index_out,
	output logic [31:0] handler_out,
	output logic [31:0] context_out,
	output logic [3:0]  entry_kind_out,
	output logic [15:0] status_out,
	output logic        last
);

	localparam int IB = INDEX_BITS;
	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_OFF1   = 4'd2;
	localparam logic [3:0] S_OFF2   = 4'd3;
	localparam logic [3:0] S_HIT    = 4'd4;
	localparam logic [3:0] S_HCHK   = 4'd5;
	localparam logic [3:0] S_EXP    = 4'd6;
	localparam logic [3:0] S_CAN    = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (SW+1)'(DEPTH)) begin
			s = s - (SW+1)'(DEPTH);
		end
		return s[SW-1:0];
	endfunction

	// sequence indexes run 1 .. 2^IB-1 and skip zero on wrap
	function automatic logic [IB-1:0] idx_inc(input logic [IB-1:0] x);
		return (x == {IB{1'b1}}) ? IB'(1) : x + 1'b1;
	endfunction

	function automatic logic [15:0] idx_out16(input logic [IB-1:0] x);
		logic [IB+15:0] w;
		w = {16'b0, x};
		return w[15:0];
	endfunction

	function automatic result_t done_res(input logic okv, input logic [15:0] idx);
		result_t r;
		r       = '0;
		r.ok    = okv;
		r.index = idx;
		r.last  = 1'b1;
		return r;
	endfunction

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [SW-1:0] head_slot_q, head_slot_d;
	logic [IB-1:0] head_idx_q, head_idx_d;
	logic [IB-1:0] newest_q, newest_d;
	logic [SW-1:0] cur_slot_q, cur_slot_d;
	logic [IB-1:0] cur_idx_q, cur_idx_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [31:0]   diff_q, diff_d;
	logic          borrow_q, borrow_d;
	logic [IB-1:0] off_q, off_d;
	logic [SW-1:0] slot_q, slot_d;
	logic [31:0]   timeout_q;
	logic [3:0]    callable_q;

	logic [2:0]    cmd_q;
	logic [31:0]   handler_q;
	logic [3:0]    kind_q;
	logic [31:0]   ctx_q;
	logic [IB-1:0] idx_q;
	logic [31:0]   now_q;
	logic [15:0]   cstat_q;

	logic          res_valid_q, res_valid_d;
	result_t       res_q, res_d;

	mem_ctl_t      mem_ctl;
	logic [SW-1:0] wr_addr, rd_addr;
	logic [31:0]   wr_hdl, rd_hdl;
	entry_t        wr_entry, rd_entry;

	logic [31:0]   alu_a, alu_b, alu_diff;
	logic          alu_borrow;

	logic [IB+15:0] seq_wide;
	logic [IB-1:0]  nx_idx;
	logic [SW-1:0]  tail_slot, off_slot, head_next;
	result_t        fire_r;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign seq_wide  = {{IB{1'b0}}, seq_index};

	assign nx_idx    = idx_inc(newest_q);
	assign tail_slot = slot_add(head_slot_q, fill_q[SW-1:0]);
	assign off_slot  = slot_add(head_slot_q, off_q[SW-1:0]);
	assign head_next = slot_inc(head_slot_q);
	assign wr_entry  = '{ctx: ctx_q, kind: kind_q, stamp: now_q};

	ort_slot_mem #(
		.DEPTH(DEPTH),
		.SW   (SW)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_hdl  (wr_hdl),
		.wr_entry(wr_entry),
		.rd_addr (rd_addr),
		.rd_hdl  (rd_hdl),
		.rd_entry(rd_entry)
	);

	ort_sub_unit u_sub (
		.a     (alu_a),
		.b     (alu_b),
		.diff  (alu_diff),
		.borrow(alu_borrow)
	);

	// operand select for the shared subtractor
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_DECODE: begin
				alu_a = 32'(idx_q);
				alu_b = 32'(head_idx_q);
			end
			S_OFF1: begin
				// wrap correction: modulus is 2^IB - 1, so subtract one on borrow
				alu_a = diff_q;
				alu_b = 32'(borrow_q);
			end
			S_OFF2: begin
				alu_a = 32'(off_q);
				alu_b = 32'(fill_q);
			end
			S_HCHK: begin
				alu_a = now_q;
				alu_b = rd_entry.stamp;
			end
			S_EXP: begin
				alu_a = timeout_q;
				alu_b = diff_q;
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	always_comb begin
		fire_r         = '0;
		fire_r.fired   = 1'b1;
		fire_r.ok      = 1'b1;
		fire_r.handler = rd_hdl;
		fire_r.ctx     = rd_entry.ctx;
		fire_r.kind    = rd_entry.kind;
		fire_r.index   = idx_out16((state_q == S_CAN) ? cur_idx_q : head_idx_q);
		fire_r.status  = (state_q == S_CAN) ? cstat_q : TIMEOUT_STATUS;
	end

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		head_slot_d = head_slot_q;
		head_idx_d  = head_idx_q;
		newest_d    = newest_q;
		cur_slot_d  = cur_slot_q;
		cur_idx_d   = cur_idx_q;
		cnt_d       = cnt_q;
		diff_d      = diff_q;
		borrow_d    = borrow_q;
		off_d       = off_q;
		slot_d      = slot_q;
		res_valid_d = 1'b0;
		res_d       = res_q;
		mem_ctl     = '0;
		wr_addr     = tail_slot;
		wr_hdl      = handler_q;
		rd_addr     = head_slot_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (cmd_q)
					CMD_ADD: begin
						res_valid_d = 1'b1;
						state_d     = S_IDLE;
						if (handler_q == '0 || fill_q == CW'(DEPTH)) begin
							res_d = done_res(1'b0, '0);
						end else begin
							mem_ctl.wr_en      = 1'b1;
							mem_ctl.wr_data_en = 1'b1;
							newest_d           = nx_idx;
							if (fill_q == '0) begin
								head_idx_d = nx_idx;
							end
							fill_d = fill_q + 1'b1;
							res_d  = done_res(1'b1, idx_out16(nx_idx));
						end
					end
					CMD_REMOVE, CMD_COMPLETE: begin
						if (idx_q == '0) begin
							res_valid_d = 1'b1;
							res_d       = done_res(1'b1, '0);
							state_d     = S_IDLE;
						end else if (fill_q == '0) begin
							res_valid_d = 1'b1;
							res_d       = done_res(1'b0, '0);
							state_d     = S_IDLE;
						end else begin
							diff_d   = alu_diff;
							borrow_d = alu_borrow;
							state_d  = S_OFF1;
						end
					end
					CMD_CHECK, CMD_CANCEL: begin
						if (fill_q == '0) begin
							res_valid_d = 1'b1;
							res_d       = done_res(1'b1, '0);
							state_d     = S_IDLE;
						end else begin
							mem_ctl.rd_en = 1'b1;
							rd_addr       = head_slot_q;
							cur_slot_d    = head_slot_q;
							cur_idx_d     = head_idx_q;
							cnt_d         = fill_q;
							state_d       = (cmd_q == CMD_CHECK) ? S_HCHK : S_CAN;
						end
					end
					default: begin
						res_valid_d = 1'b1;
						res_d       = done_res(1'b0, '0);
						state_d     = S_IDLE;
					end
				endcase
			end
			S_OFF1: begin
				off_d   = alu_diff[IB-1:0];
				state_d = S_OFF2;
			end
			S_OFF2: begin
				if (!alu_borrow) begin
					// distance from head not below fill: index not in the ring
					res_valid_d = 1'b1;
					res_d       = done_res(1'b0, '0);
					state_d     = S_IDLE;
				end else begin
					slot_d        = off_slot;
					mem_ctl.rd_en = 1'b1;
					rd_addr       = off_slot;
					state_d       = S_HIT;
				end
			end
			S_HIT: begin
				res_valid_d = 1'b1;
				state_d     = S_IDLE;
				if (cmd_q == CMD_COMPLETE) begin
					res_d         = done_res(1'b1, idx_out16(idx_q));
					res_d.handler = rd_hdl;
					res_d.ctx     = rd_entry.ctx;
					res_d.kind    = rd_entry.kind;
				end else begin
					res_d = done_res(1'b1, '0);
				end
				if (off_q == '0) begin
					head_slot_d = head_next;
					head_idx_d  = idx_inc(head_idx_q);
					fill_d      = fill_q - 1'b1;
					if (cmd_q == CMD_COMPLETE && fill_q > CW'(1)) begin
						mem_ctl.rd_en = 1'b1;
						rd_addr       = head_next;
						state_d       = S_HCHK;
					end
				end else begin
					mem_ctl.wr_en = 1'b1;
					wr_addr       = slot_q;
					wr_hdl        = '0;
				end
			end
			S_HCHK: begin
				// head walk: drop invalid entries one a cycle
				if (rd_hdl == '0) begin
					head_slot_d = head_next;
					head_idx_d  = idx_inc(head_idx_q);
					fill_d      = fill_q - 1'b1;
					if (fill_q > CW'(1)) begin
						mem_ctl.rd_en = 1'b1;
						rd_addr       = head_next;
					end else begin
						state_d = S_IDLE;
						if (cmd_q == CMD_CHECK) begin
							res_valid_d = 1'b1;
							res_d       = done_res(1'b1, '0);
						end
					end
				end else if (cmd_q == CMD_CHECK) begin
					diff_d  = alu_diff;
					state_d = S_EXP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EXP: begin
				if (alu_borrow) begin
					// age exceeds timeout
					if (rd_entry.kind == callable_q) begin
						res_valid_d = 1'b1;
						res_d       = fire_r;
					end
					head_slot_d = head_next;
					head_idx_d  = idx_inc(head_idx_q);
					fill_d      = fill_q - 1'b1;
					if (fill_q > CW'(1)) begin
						mem_ctl.rd_en = 1'b1;
						rd_addr       = head_next;
						state_d       = S_HCHK;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					res_valid_d = 1'b1;
					res_d       = done_res(1'b1, '0);
					state_d     = S_IDLE;
				end
			end
			S_CAN: begin
				if (rd_hdl != '0 && rd_entry.kind == callable_q) begin
					res_valid_d = 1'b1;
					res_d       = fire_r;
				end
				if (cnt_q == CW'(1)) begin
					state_d = S_DONE;
				end else begin
					cnt_d         = cnt_q - 1'b1;
					cur_slot_d    = slot_inc(cur_slot_q);
					cur_idx_d     = idx_inc(cur_idx_q);
					mem_ctl.rd_en = 1'b1;
					rd_addr       = slot_inc(cur_slot_q);
				end
			end
			S_DONE: begin
				res_valid_d = 1'b1;
				res_d       = done_res(1'b1, '0);
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			head_slot_q <= '0;
			head_idx_q  <= '0;
			newest_q    <= '0;
			cmd_q       <= CMD_ADD;
			res_valid_q <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
			callable_q  <= '0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			head_slot_q <= head_slot_d;
			head_idx_q  <= head_idx_d;
			newest_q    <= newest_d;
			res_valid_q <= res_valid_d;
			if (start && !busy) begin
				cmd_q <= cmd;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TIMEOUT:  timeout_q  <= cfg_data;
					CFG_CALLABLE: callable_q <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_slot_q <= cur_slot_d;
		cur_idx_q  <= cur_idx_d;
		cnt_q      <= cnt_d;
		diff_q     <= diff_d;
		borrow_q   <= borrow_d;
		off_q      <= off_d;
		slot_q     <= slot_d;
		res_q      <= res_d;
		if (start && !busy) begin
			handler_q <= handler;
			kind_q    <= entry_kind_in;
			ctx_q     <= context_in;
			idx_q     <= seq_wide[IB-1:0];
			now_q     <= now;
			cstat_q   <= cancel_status;
		end
	end

	assign result_valid   = res_valid_q;
	assign fired          = res_q.fired;
	assign ok             = res_q.ok;
	assign index_out      = res_q.index;
	assign handler_out    = res_q.handler;
	assign context_out    = res_q.ctx;
	assign entry_kind_out = res_q.kind;
	assign status_out     = res_q.status;
	assign last           = res_q.last;

	`ORT_ASSERT_ALWAYS(a_fill_bound, fill_q <= CW'(DEPTH), "fill count beyond ring depth")
	`ORT_ASSERT_NEXT(a_idle_holds_ring, state_q == S_IDLE, $stable(fill_q) && $stable(head_slot_q), "ring moved while idle")
	`ORT_ASSERT_IMPL(a_result_from_work, res_valid_q, $past(state_q) != S_IDLE, "result without a command in flight")
	`ORT_ASSERT_NEXT(a_start_takes, start && !busy, busy && state_q == S_DECODE, "accepted command not decoded")

endmodule

`default_nettype wire

/* verif/outstanding_request_tracker_tb.sv */
`timescale 1ns / 1ps

module outstanding_request_tracker_tb;
	import ort_pkg::*;

	localparam int RING = 16;
	localparam longint unsigned SEQ_SPAN = 65535;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 70;
	localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] hnd;
		logic [3:0]  kind;
		logic [31:0] ctx;
		logic [15:0] seq;
		logic [31:0] tick;
		logic [15:0] status;
	} cmd_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  cmd = CMD_ADD;
	logic [31:0] handler = '0;
	logic [3:0]  entry_kind_in = '0;
	logic [31:0] context_in = '0;
	logic [15:0] seq_index = '0;
	logic [31:0] now = '0;
	logic [15:0] cancel_status = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_TIMEOUT;
	logic [31:0] cfg_data = '0;
	logic        result_valid;
	logic        fired;
	logic        ok;
	logic [15:0] index_out;
	logic [31:0] handler_out;
	logic [31:0] context_out;
	logic [3:0]  entry_kind_out;
	logic [15:0] status_out;
	logic        last;

	outstanding_request_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.handler(handler),
		.entry_kind_in(entry_kind_in),
		.context_in(context_in),
		.seq_index(seq_index),
		.now(now),
		.cancel_status(cancel_status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.fired(fired),
		.ok(ok),
		.index_out(index_out),
		.handler_out(handler_out),
		.context_out(context_out),
		.entry_kind_out(entry_kind_out),
		.status_out(status_out),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tracker shadow state
	logic [31:0] trk_handler [RING];
	logic [31:0] trk_ctx [RING];
	logic [3:0]  trk_kind [RING];
	logic [31:0] trk_stamp [RING];
	int unsigned trk_head = 0;
	int unsigned trk_fill = 0;
	int unsigned trk_newest = 0;
	logic [31:0] timeout_reg = TIMEOUT_RESET;
	logic [3:0]  callable_reg = '0;

	result_t     pending_results [$];
	result_t     want;
	int unsigned fails = 0;
	int unsigned cycles = 0;
	logic [31:0] tb_now = '0;
	bit          idle_on = 1'b1;

	// sequence index of the live request at offset off from the head
	function automatic int unsigned seq_at(int unsigned off);
		longint unsigned nz, back, head0;
		nz = (trk_newest == 0) ? 0 : trk_newest - 1;
		back = (trk_fill == 0) ? 0 : (trk_fill - 1) % SEQ_SPAN;
		head0 = (nz + SEQ_SPAN - back) % SEQ_SPAN;
		return 32'(((head0 + off) % SEQ_SPAN) + 1);
	endfunction

	function automatic void pop_head();
		if (trk_fill != 0) begin
			trk_head = (trk_head + 1) % RING;
			trk_fill--;
		end
	endfunction

	function automatic void queue_result(result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void expect_done(logic okv, logic [15:0] idx, logic [31:0] h,
			logic [31:0] c, logic [3:0] k);
		result_t r;
		r.fired = 1'b0;
		r.ok = okv;
		r.index = idx;
		r.handler = h;
		r.ctx = c;
		r.kind = k;
		r.status = '0;
		r.last = 1'b1;
		queue_result(r);
	endfunction

	function automatic void expect_fire(int unsigned off, logic [15:0] st);
		result_t r;
		int unsigned slot;
		slot = (trk_head + off) % RING;
		r.fired = 1'b1;
		r.ok = 1'b1;
		r.index = 16'(seq_at(off));
		r.handler = trk_handler[slot];
		r.ctx = trk_ctx[slot];
		r.kind = trk_kind[slot];
		r.status = st;
		r.last = 1'b0;
		queue_result(r);
	endfunction

	function automatic void predict(cmd_item_t it);
		longint unsigned off;
		int unsigned slot, nx;
		logic [31:0] age;
		bit halt;
		case (it.op)
			CMD_ADD: begin
				if (it.hnd == '0 || trk_fill >= RING) begin
					expect_done(1'b0, '0, '0, '0, '0);
				end else begin
					nx = (trk_newest + 1) & 32'hFFFF;
					if (nx == 0)
						nx = 1;
					trk_newest = nx;
					slot = (trk_head + trk_fill) % RING;
					trk_handler[slot] = it.hnd;
					trk_ctx[slot] = it.ctx;
					trk_kind[slot] = it.kind;
					trk_stamp[slot] = it.tick;
					trk_fill++;
					expect_done(1'b1, 16'(nx), '0, '0, '0);
				end
			end
			CMD_REMOVE, CMD_COMPLETE: begin
				if (it.seq == '0) begin
					expect_done(1'b1, '0, '0, '0, '0);
				end else if (trk_fill == 0) begin
					expect_done(1'b0, '0, '0, '0, '0);
				end else begin
					off = (longint'(it.seq) - 1 + SEQ_SPAN - (seq_at(0) - 1)) % SEQ_SPAN;
					if (off >= trk_fill) begin
						expect_done(1'b0, '0, '0, '0, '0);
					end else begin
						slot = 32'((trk_head + off) % RING);
						if (it.op == CMD_REMOVE) begin
							if (off == 0)
								pop_head();
							else
								trk_handler[slot] = '0;
							expect_done(1'b1, '0, '0, '0, '0);
						end else begin
							expect_done(1'b1, it.seq, trk_handler[slot], trk_ctx[slot],
								trk_kind[slot]);
							if (off == 0) begin
								pop_head();
								// drop requests already retired behind the head
								while (trk_fill > 0 && trk_handler[trk_head] == '0)
									pop_head();
							end else begin
								trk_handler[slot] = '0;
							end
						end
					end
				end
			end
			CMD_CHECK: begin
				halt = 1'b0;
				while (trk_fill > 0 && !halt) begin
					slot = trk_head;
					age = it.tick - trk_stamp[slot];
					if (trk_handler[slot] == '0) begin
						pop_head();
					end else if (age > timeout_reg) begin
						if (trk_kind[slot] == callable_reg)
							expect_fire(0, TIMEOUT_STATUS);
						pop_head();
					end else begin
						halt = 1'b1;
					end
				end
				expect_done(1'b1, '0, '0, '0, '0);
			end
			CMD_CANCEL: begin
				for (int unsigned i = 0; i < trk_fill; i++) begin
					slot = (trk_head + i) % RING;
					if (trk_handler[slot] != '0 && trk_kind[slot] == callable_reg)
						expect_fire(i, it.status);
				end
				expect_done(1'b1, '0, '0, '0, '0);
			end
			default: begin
				expect_done(1'b0, '0, '0, '0, '0);
			end
		endcase
	endfunction

	function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: index_out %0h last %0b", index_out, last);
				fails++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				compare_field("fired", 32'(want.fired), 32'(fired));
				compare_field("ok", 32'(want.ok), 32'(ok));
				compare_field("index_out", 32'(want.index), 32'(index_out));
				compare_field("handler_out", want.handler, handler_out);
				compare_field("context_out", want.ctx, context_out);
				compare_field("entry_kind_out", 32'(want.kind), 32'(entry_kind_out));
				compare_field("status_out", 32'(want.status), 32'(status_out));
				compare_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic cmd_item_t mk(logic [2:0] op, logic [31:0] hnd, logic [3:0] kind,
			logic [31:0] ctx, logic [15:0] seq, logic [31:0] tick, logic [15:0] status);
		cmd_item_t it;
		it.op = op;
		it.hnd = hnd;
		it.kind = kind;
		it.ctx = ctx;
		it.seq = seq;
		it.tick = tick;
		it.status = status;
		return it;
	endfunction

	function automatic cmd_item_t rand_add(logic [3:0] kind);
		cmd_item_t it;
		it = mk(CMD_ADD, $urandom(), kind, $urandom(), 16'($urandom()), tb_now,
			16'($urandom()));
		if (it.hnd == '0)
			it.hnd = 32'd1;
		return it;
	endfunction

	// mostly live indexes, head-heavy, with some zero and stray ones
	function automatic logic [15:0] pick_index();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (trk_fill > 0 && roll < 3)
			return 16'(seq_at(0));
		if (trk_fill > 0 && roll < 8)
			return 16'(seq_at($urandom_range(0, trk_fill - 1)));
		if (roll == 8)
			return '0;
		return 16'($urandom());
	endfunction

	// item is taken at the first edge with start high and busy low
	task automatic issue(cmd_item_t it);
		cmd <= it.op;
		handler <= it.hnd;
		entry_kind_in <= it.kind;
		context_in <= it.ctx;
		seq_index <= it.seq;
		now <= it.tick;
		cancel_status <= it.status;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict(it);
	endtask

	task automatic hold_off(int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send(cmd_item_t it);
		issue(it);
		if (idle_on && $urandom_range(0, 3) == 0)
			hold_off($urandom_range(1, 7));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// complete may still be sweeping the head after its done item
		while (busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_TIMEOUT)
			timeout_reg = data;
		else if (idx == CFG_CALLABLE)
			callable_reg = data[3:0];
	endtask

	task automatic configure(logic [31:0] tmo, logic [3:0] kind);
		drain();
		write_reg(CFG_TIMEOUT, tmo);
		write_reg(CFG_CALLABLE, ($urandom() & 32'hFFFF_FFF0) | 32'(kind));
		write_reg(CFG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random();
		cmd_item_t r;
		int unsigned roll;
		tb_now = tb_now + $urandom_range(0, 6);
		r = mk(CMD_ADD, $urandom(), 4'($urandom()), $urandom(), 16'($urandom()), tb_now,
			16'($urandom()));
		if ($urandom_range(0, 49) == 0)
			r.tick = $urandom();
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			if (roll < 3)
				r.hnd = '0;
			else if (r.hnd == '0)
				r.hnd = 32'd1;
			if ($urandom_range(0, 1) == 1)
				r.kind = callable_reg;
		end else if (roll < 60) begin
			r.op = CMD_REMOVE;
			r.seq = pick_index();
		end else if (roll < 78) begin
			r.op = CMD_COMPLETE;
			r.seq = pick_index();
		end else if (roll < 90) begin
			r.op = CMD_CHECK;
		end else if (roll < 97) begin
			r.op = CMD_CANCEL;
		end else begin
			r.op = 3'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
		end
		send(r);
	endtask

	task automatic test_directed();
		send(mk(CMD_ADD, '0, 4'd3, 32'h1234, '0, '0, '0));
		send(mk(CMD_REMOVE, '0, '0, '0, 16'd0, '0, '0));
		send(mk(CMD_COMPLETE, '0, '0, '0, 16'd0, '0, '0));
		send(mk(CMD_REMOVE, '0, '0, '0, 16'd3, '0, '0));
		send(mk(CMD_COMPLETE, '0, '0, '0, 16'hFFFF, '0, '0));
		send(mk(CMD_UNKNOWN_LO, '1, '1, '1, '1, '1, '1));
		send(mk(CMD_UNKNOWN_HI, '0, '0, '0, '0, '0, '0));
		send(mk(CMD_ADD, 32'hFFFF_FFFF, 4'd0, 32'hFFFF_FFFF, '0, 32'd0, '0));
		send(mk(CMD_ADD, 32'd1, 4'd0, 32'd0, '0, 32'd5, '0));
		send(mk(CMD_ADD, 32'd2, 4'hF, 32'h1234_5678, '0, 32'd7, '0));
		send(mk(CMD_ADD, 32'd3, 4'd0, 32'hA5A5_5A5A, '0, 32'hFFFF_FFFF, '0));
		// retire a request behind the head, then complete it again
		send(mk(CMD_REMOVE, '0, '0, '0, 16'd2, '0, '0));
		send(mk(CMD_COMPLETE, '0, '0, '0, 16'd2, '0, '0));
		send(mk(CMD_COMPLETE, '0, '0, '0, 16'd9, '0, '0));
		send(mk(CMD_CANCEL, '0, '0, '0, '0, '0, 16'hFFFF));
		send(mk(CMD_COMPLETE, '0, '0, '0, 16'd1, '0, '0));
		send(mk(CMD_REMOVE, '0, '0, '0, 16'd3, '0, '0));
		// age wraps past zero on this one
		send(mk(CMD_CHECK, '0, '0, '0, '0, 32'd20, '0));
		send(mk(CMD_ADD, 32'h8000_0000, 4'd0, 32'h5555_5555, '0, 32'd100, '0));
		send(mk(CMD_CHECK, '0, '0, '0, '0, 32'd110, '0));
		send(mk(CMD_CHECK, '0, '0, '0, '0, 32'd111, '0));
	endtask

	task automatic test_full_ring();
		configure(32'hFFFF_FFFF, 4'd5);
		while (trk_fill < RING)
			send(rand_add(4'd5));
		repeat (2) send(rand_add(4'($urandom())));
		send(mk(CMD_CANCEL, '0, '0, '0, '0, tb_now, 16'($urandom())));
		send(mk(CMD_REMOVE, '0, '0, '0, 16'(seq_at(1)), '0, '0));
		send(mk(CMD_REMOVE, '0, '0, '0, 16'(seq_at(2)), '0, '0));
		send(mk(CMD_COMPLETE, '0, '0, '0, 16'(seq_at(0)), '0, '0));
		send(mk(CMD_CHECK, '0, '0, '0, '0, $urandom(), '0));
	endtask

	task automatic test_config_sweep();
		logic [31:0] tmo [5];
		logic [3:0] kinds [5];
		tmo = '{TIMEOUT_RESET, 32'd0, 32'hFFFF_FFFF, 32'd40, 32'd3};
		kinds = '{4'd0, 4'hF, 4'd9, 4'd6, 4'd2};
		tb_now = $urandom();
		for (int i = 0; i < 5; i++) begin
			configure(tmo[i], kinds[i]);
			if (i == 3)
				tb_now = 32'hFFFF_FFC0;
			repeat (PHASE_ITEMS) send_random();
		end
	endtask

	task automatic test_quiet_tail();
		configure($urandom_range(0, 30), 4'($urandom()));
		idle_on = 1'b0;
		repeat (60) send_random();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_ring();
		test_config_sweep();
		test_quiet_tail();
		drain();
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
